>>> design/blp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_pkg
// Shared widths, codes and transfer types for the bounded positional list.
// ----------------------------------------------------------------------------
package blp_pkg;

	// List geometry
	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);

	// Request and result field widths
	localparam int FUNC_W   = 4;
	localparam int POS_W    = 5;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;

	// Width used to compare a position against the element count
	localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

	// Operation codes
	localparam logic [FUNC_W-1:0] FN_INS_START = 4'd0;
	localparam logic [FUNC_W-1:0] FN_INS_END   = 4'd1;
	localparam logic [FUNC_W-1:0] FN_INS_POS   = 4'd2;
	localparam logic [FUNC_W-1:0] FN_REM_START = 4'd3;
	localparam logic [FUNC_W-1:0] FN_REM_END   = 4'd4;
	localparam logic [FUNC_W-1:0] FN_REM_POS   = 4'd5;
	localparam logic [FUNC_W-1:0] FN_FIRST     = 4'd6;
	localparam logic [FUNC_W-1:0] FN_LAST      = 4'd7;
	localparam logic [FUNC_W-1:0] FN_READ_POS  = 4'd8;
	localparam logic [FUNC_W-1:0] FN_ROTATE    = 4'd9;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	// Shift commands for the cell row
	localparam logic [1:0] SH_NONE = 2'd0;
	localparam logic [1:0] SH_INS  = 2'd1;
	localparam logic [1:0] SH_REM  = 2'd2;
	localparam logic [1:0] SH_ROT  = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]    data;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic                load;
		logic                exec;
		logic [1:0]          shift;
		logic [IDX_W-1:0]    idx;
		logic                rd;
		logic [STATUS_W-1:0] status;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [POS_W-1:0]  position;
		logic [CNT_W-1:0]  count;
	} dp_stat_t;

endpackage

>>> design/blp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_ctrl
// Request controller: captures a request, then decodes it against the
// element count into a shift command, a read and a status.
// ----------------------------------------------------------------------------
module blp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  blp_pkg::dp_stat_t stat,
	output blp_pkg::ctl_cmd_t cmd
);
	import blp_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic             state_q;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic             full;
	logic             empty;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] pos_idx;
	logic [IDX_W-1:0] end_idx;

	// Advance: enter the execute state after each capture, then return to idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_EXEC;
				S_EXEC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q == S_EXEC);

	assign pos_c    = CMP_W'(stat.position);
	assign cnt_c    = CMP_W'(stat.count);
	assign full     = (cnt_c >= CMP_W'(CAPACITY));
	assign empty    = (cnt_c == '0);
	assign end_idx  = IDX_W'(stat.count);
	assign last_idx = IDX_W'(stat.count - CNT_W'(1));
	assign pos_idx  = IDX_W'(stat.position);

	// Decode the held request into a command for the cell row
	always_comb begin
		cmd        = '0;
		cmd.load   = start && !busy;
		cmd.exec   = busy;
		cmd.shift  = SH_NONE;
		cmd.status = ST_OK;
		unique case (stat.func)
			FN_INS_START, FN_INS_END: begin
				if (full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.shift = SH_INS;
					cmd.idx   = (stat.func == FN_INS_START) ? '0 : end_idx;
				end
			end
			FN_INS_POS: begin
				if (pos_c > cnt_c) begin
					cmd.status = ST_RANGE;
				end else if (full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.shift = SH_INS;
					cmd.idx   = pos_idx;
				end
			end
			FN_REM_START, FN_REM_END: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.shift = SH_REM;
					cmd.rd    = 1'b1;
					cmd.idx   = (stat.func == FN_REM_START) ? '0 : last_idx;
				end
			end
			FN_REM_POS: begin
				if (pos_c >= cnt_c) begin
					cmd.status = ST_RANGE;
				end else begin
					cmd.shift = SH_REM;
					cmd.rd    = 1'b1;
					cmd.idx   = pos_idx;
				end
			end
			FN_FIRST, FN_LAST: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.rd  = 1'b1;
					cmd.idx = (stat.func == FN_FIRST) ? '0 : last_idx;
				end
			end
			FN_READ_POS: begin
				if (pos_c >= cnt_c) begin
					cmd.status = ST_RANGE;
				end else begin
					cmd.rd  = 1'b1;
					cmd.idx = pos_idx;
				end
			end
			FN_ROTATE: begin
				if (cnt_c > CMP_W'(1)) begin
					cmd.shift = SH_ROT;
					cmd.idx   = last_idx;
				end
			end
			default: begin
				cmd.shift = SH_NONE;
			end
		endcase
	end

endmodule

>>> design/blp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blp_datapath
// Request register, row of shift cells, element count and result register.
// ----------------------------------------------------------------------------
module blp_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  blp_pkg::req_t     req,
	input  blp_pkg::ctl_cmd_t cmd,
	output blp_pkg::dp_stat_t stat,
	output logic              done,
	output blp_pkg::rsp_t     rsp
);
	import blp_pkg::*;

	req_t                  req_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic [DATA_WIDTH-1:0] cells_q   [CAPACITY];
	logic [DATA_WIDTH-1:0] cells_nxt [CAPACITY];
	logic [DATA_WIDTH-1:0] prev_w    [CAPACITY];
	logic [DATA_WIDTH-1:0] next_w    [CAPACITY];
	logic [DATA_WIDTH-1:0] ins_val;
	logic [DATA_WIDTH-1:0] rd_val;
	rsp_t                  rsp_q;
	logic                  done_q;

	// Hold the request for the execute cycle
	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
	end

	assign stat.func     = req_q.func;
	assign stat.position = req_q.position;
	assign stat.count    = count_q;

	assign ins_val = DATA_WIDTH'(req_q.value);
	assign rd_val  = cmd.rd ? cells_q[cmd.idx] : '0;

	// Neighbour taps of each cell
	for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
		if (g == 0) begin : g_first
			assign prev_w[g] = cells_q[g];
		end else begin : g_mid
			assign prev_w[g] = cells_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign next_w[g] = cells_q[g];
		end else begin : g_mid2
			assign next_w[g] = cells_q[g+1];
		end
	end

	// Next value of each cell: open a gap, close a gap or wrap the head
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cells_nxt[i] = cells_q[i];
			case (cmd.shift)
				SH_INS: begin
					if (IDX_W'(i) == cmd.idx) cells_nxt[i] = ins_val;
					else if (IDX_W'(i) > cmd.idx) cells_nxt[i] = prev_w[i];
				end
				SH_REM: begin
					if (IDX_W'(i) >= cmd.idx) cells_nxt[i] = next_w[i];
				end
				SH_ROT: begin
					if (IDX_W'(i) == cmd.idx) cells_nxt[i] = cells_q[0];
					else if (IDX_W'(i) < cmd.idx) cells_nxt[i] = next_w[i];
				end
				default: cells_nxt[i] = cells_q[i];
			endcase
		end
	end

	always_comb begin
		case (cmd.shift)
			SH_INS:  count_nxt = count_q + CNT_W'(1);
			SH_REM:  count_nxt = count_q - CNT_W'(1);
			default: count_nxt = count_q;
		endcase
	end

	// Update the cell row
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			for (int i = 0; i < CAPACITY; i++) cells_q[i] <= cells_nxt[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) count_q <= count_nxt;
		end
	end

	// Register the result of the execute cycle
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rsp_q.data   <= VAL_W'(rd_val);
			rsp_q.status <= cmd.status;
			rsp_q.count  <= COUNT_W'(count_nxt);
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> design/bounded_positional_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_positional_list_unit
// Ordered list of up to CAPACITY values with positional insert, remove,
// read and rotate; one result per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. busy then stays high
// while the request executes on the row of shift cells, and a new request is
// taken only once busy is low again.
// The result appears on rsp for exactly one cycle with done high, in the
// cycle after busy; there is no way to hold it, so the receiver must capture
// it then. Each request gives exactly one result.
module bounded_positional_list_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  blp_pkg::req_t  req,
	output logic           done,
	output blp_pkg::rsp_t  rsp
);
	import blp_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	blp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	blp_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.done   (done),
		.rsp    (rsp)
	);

	// Every execute cycle yields a result transfer in the next cycle
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("execute cycle without result");

	// A result transfer only follows an execute cycle
	a_done_after: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result without execute cycle");

	// Count never exceeds capacity
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.count <= COUNT_W'(CAPACITY)))
		else $error("count beyond capacity");

	// Failed requests return zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.data == '0))
		else $error("nonzero data on failed request");

endmodule
